FILE: hw/rtl/isc_pkg.sv
package isc_pkg;

  localparam int ACC_W      = 16;
  localparam int RATE_IN_W  = 16;
  localparam int RATE_OUT_W = 17;
  localparam int TEMP_IN_W  = 16;
  localparam int TEMP_W     = 16;
  localparam int ROLL_W     = 18;
  localparam int BIAS_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NLANE      = 3;

  localparam int WIN_LEN = 5;
  localparam int POS_W   = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int CNT_W   = $clog2(WIN_LEN + 1);
  localparam int SUM_W   = ROLL_W + $clog2(WIN_LEN);

  localparam int DIV_STEP = 7;
  localparam int DIV_CYC  = (SUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DVD_PAD  = DIV_CYC * DIV_STEP;
  localparam int DCNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  localparam int RATE_NUM = 40;
  localparam int RATE_DEN = 41;
  localparam int RATE_N_W = 21;
  localparam int RATE_K   = 21;
  localparam int RATE_M_W = 16;
  localparam int RATE_M   = (2 ** RATE_K) / RATE_DEN;
  localparam int RATE_Q_W = 16;

  localparam int TEMP_NUM = 25600;
  localparam int TEMP_DEN = 33387;
  localparam int TEMP_N_W = 30;
  localparam int TEMP_K   = 30;
  localparam int TEMP_M_W = 16;
  localparam int TEMP_M   = (2 ** TEMP_K) / TEMP_DEN;
  localparam int TEMP_Q_W = 16;
  localparam int TEMP_OFS = 5376;

  localparam int ROLL_NUM = 45;
  localparam int ROLL_SH  = 4;
  localparam int ROLL_N_W = 21;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIAS_X = 2'd0,
    REG_BIAS_Y = 2'd1,
    REG_BIAS_Z = 2'd2
  } isc_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC1,
    ST_CALC2,
    ST_CALC3,
    ST_DIV,
    ST_FIN
  } isc_state_t;

  typedef struct packed {
    logic load;
    logic win_upd;
    logic div_load;
    logic div_step;
    logic out_load;
  } isc_cmd_t;

  typedef struct packed {
    logic prime;
  } isc_sts_t;

endpackage

FILE: hw/rtl/isc_div.sv
module isc_div (
  input  logic                                clk,
  input  logic                                load,
  input  logic                                step,
  input  logic [isc_pkg::SUM_W-1:0]           dividend,
  input  logic [isc_pkg::CNT_W-1:0]           divisor,
  input  logic                                neg,
  output logic signed [isc_pkg::ROLL_W-1:0]   quot
);
  import isc_pkg::*;

  logic [DVD_PAD-1:0] dq_r;
  logic [DVD_PAD-1:0] dq_nxt;
  logic [CNT_W-1:0]   rem_r;
  logic [CNT_W-1:0]   rem_nxt;
  logic [CNT_W-1:0]   dvs_r;
  logic               neg_r;
  logic [CNT_W:0]     rem_t;
  logic [DVD_PAD-1:0] dq_t;
  logic [ROLL_W-1:0]  qv;

  always_comb begin
    rem_t = {1'b0, rem_r};
    dq_t  = dq_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      rem_t = {rem_t[CNT_W-1:0], dq_t[DVD_PAD-1]};
      dq_t  = {dq_t[DVD_PAD-2:0], 1'b0};
      if (rem_t >= {1'b0, dvs_r}) begin
        rem_t    = rem_t - {1'b0, dvs_r};
        dq_t[0]  = 1'b1;
      end
    end
    rem_nxt = rem_t[CNT_W-1:0];
    dq_nxt  = dq_t;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dq_r  <= DVD_PAD'(dividend);
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= neg;
    end else if (step) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign qv   = dq_r[ROLL_W-1:0];
  assign quot = neg_r ? -$signed(qv) : $signed(qv);

endmodule

FILE: hw/rtl/isc_ctrl.sv
module isc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  isc_pkg::isc_sts_t   sts,
  output isc_pkg::isc_cmd_t   cmd
);
  import isc_pkg::*;

  isc_state_t        state_r;
  isc_state_t        state_nxt;
  logic [DCNT_W-1:0] cnt_r;
  logic [DCNT_W-1:0] cnt_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC1;
        end
      end
      ST_CALC1: begin
        state_nxt = ST_CALC2;
      end
      ST_CALC2: begin
        cmd.win_upd = 1'b1;
        state_nxt   = sts.prime ? ST_IDLE : ST_CALC3;
      end
      ST_CALC3: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DCNT_W'(DIV_CYC - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/isc_datapath.sv
module isc_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [isc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [isc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic signed [isc_pkg::ACC_W-1:0]      in_accel_x,
  input  logic signed [isc_pkg::ACC_W-1:0]      in_accel_y,
  input  logic signed [isc_pkg::ACC_W-1:0]      in_accel_z,
  input  logic signed [isc_pkg::RATE_IN_W-1:0]  in_rate_x,
  input  logic signed [isc_pkg::RATE_IN_W-1:0]  in_rate_y,
  input  logic signed [isc_pkg::RATE_IN_W-1:0]  in_rate_z,
  input  logic signed [isc_pkg::TEMP_IN_W-1:0]  in_raw_temp,
  input  logic                                  in_prime,
  input  isc_pkg::isc_cmd_t                     cmd,
  output isc_pkg::isc_sts_t                     sts,
  output logic signed [isc_pkg::ACC_W-1:0]      out_accel_x,
  output logic signed [isc_pkg::ACC_W-1:0]      out_accel_y,
  output logic signed [isc_pkg::ACC_W-1:0]      out_accel_z,
  output logic signed [isc_pkg::RATE_OUT_W-1:0] out_rate_x,
  output logic signed [isc_pkg::RATE_OUT_W-1:0] out_rate_y,
  output logic signed [isc_pkg::RATE_OUT_W-1:0] out_rate_z,
  output logic signed [isc_pkg::TEMP_W-1:0]     out_temp_c,
  output logic signed [isc_pkg::ROLL_W-1:0]     out_roll,
  output logic signed [isc_pkg::ROLL_W-1:0]     out_roll_mean
);
  import isc_pkg::*;

  localparam int RPROD_W = RATE_N_W + RATE_M_W;
  localparam int TPROD_W = TEMP_N_W + TEMP_M_W;

  // captured transaction
  logic signed [ACC_W-1:0]     ax_r, ay_r, az_r;
  logic signed [RATE_IN_W-1:0] rate_r [NLANE];
  logic signed [TEMP_IN_W-1:0] temp_r;
  logic                        prime_r;

  // configuration and window state
  logic signed [BIAS_W-1:0] bias_r [NLANE];
  logic signed [ROLL_W-1:0] win_r [WIN_LEN];
  logic [POS_W-1:0]         pos_r;
  logic [CNT_W-1:0]         fill_r;
  logic signed [SUM_W-1:0]  sum_r;

  // first stage
  logic [RATE_IN_W-1:0] rmag [NLANE];
  logic [RATE_N_W-1:0]  rn [NLANE];
  logic [RPROD_W-1:0]   rprod [NLANE];
  logic [RATE_N_W-1:0]  rn_r [NLANE];
  logic [RATE_Q_W-1:0]  rq0_r [NLANE];
  logic [TEMP_IN_W-1:0] tmag;
  logic [TEMP_N_W-1:0]  tn;
  logic [TPROD_W-1:0]   tprod;
  logic [TEMP_N_W-1:0]  tn_r;
  logic [TEMP_Q_W-1:0]  tq0_r;
  logic [ACC_W-1:0]     amag;
  logic [ROLL_N_W-1:0]  rolln;
  logic [ROLL_W-1:0]    rollmag;
  logic signed [ROLL_W-1:0] roll_r;

  // second stage
  logic [RATE_N_W-1:0] rmul [NLANE];
  logic [RATE_N_W-1:0] rrem [NLANE];
  logic [RATE_Q_W-1:0] rq_r [NLANE];
  logic [TEMP_N_W-1:0] tmul;
  logic [TEMP_N_W-1:0] trem;
  logic [TEMP_Q_W-1:0] tq_r;

  // third stage
  logic signed [RATE_OUT_W-1:0] rs [NLANE];
  logic signed [RATE_OUT_W-1:0] rate_o_r [NLANE];
  logic signed [TEMP_W:0]       ts;
  logic signed [TEMP_W-1:0]     temp_o_r;

  // divider feed
  logic [SUM_W-1:0]         sum_mag;
  logic [SUM_W-1:0]         dvd;
  logic signed [ROLL_W-1:0] mean;

  // result register
  logic signed [ACC_W-1:0]      oax_r, oay_r, oaz_r;
  logic signed [RATE_OUT_W-1:0] orate_r [NLANE];
  logic signed [TEMP_W-1:0]     otemp_r;
  logic signed [ROLL_W-1:0]     oroll_r;
  logic signed [ROLL_W-1:0]     omean_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r      <= in_accel_x;
      ay_r      <= in_accel_y;
      az_r      <= in_accel_z;
      rate_r[0] <= in_rate_x;
      rate_r[1] <= in_rate_y;
      rate_r[2] <= in_rate_z;
      temp_r    <= in_raw_temp;
      prime_r   <= in_prime;
    end
  end

  assign sts.prime = prime_r;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      rmag[i]  = rate_r[i][RATE_IN_W-1] ? (~rate_r[i] + 1'b1) : rate_r[i];
      rn[i]    = RATE_N_W'(rmag[i]) * RATE_N_W'(RATE_NUM) + RATE_N_W'(RATE_DEN / 2);
      rprod[i] = RPROD_W'(rn[i]) * RPROD_W'(RATE_M);
      rmul[i]  = RATE_N_W'(rq0_r[i]) * RATE_N_W'(RATE_DEN);
      rrem[i]  = rn_r[i] - rmul[i];
      rs[i]    = (rate_r[i][RATE_IN_W-1] ? -$signed({1'b0, rq_r[i]})
                                         : $signed({1'b0, rq_r[i]}))
                 - RATE_OUT_W'(bias_r[i]);
    end
    tmag    = temp_r[TEMP_IN_W-1] ? (~temp_r + 1'b1) : temp_r;
    tn      = TEMP_N_W'(tmag) * TEMP_N_W'(TEMP_NUM) + TEMP_N_W'(TEMP_DEN / 2);
    tprod   = TPROD_W'(tn) * TPROD_W'(TEMP_M);
    tmul    = TEMP_N_W'(tq0_r) * TEMP_N_W'(TEMP_DEN);
    trem    = tn_r - tmul;
    ts      = (temp_r[TEMP_IN_W-1] ? -$signed({1'b0, tq_r}) : $signed({1'b0, tq_r}))
              + (TEMP_W + 1)'(TEMP_OFS);
    amag    = ay_r[ACC_W-1] ? (~ay_r + 1'b1) : ay_r;
    rolln   = ROLL_N_W'(amag) * ROLL_N_W'(ROLL_NUM) + ROLL_N_W'((2 ** ROLL_SH) / 2);
    rollmag = ROLL_W'(rolln >> ROLL_SH);
    sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
    dvd     = sum_mag + SUM_W'(fill_r >> 1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NLANE; i++) begin
      rn_r[i]     <= rn[i];
      rq0_r[i]    <= rprod[i][RATE_K +: RATE_Q_W];
      rq_r[i]     <= rq0_r[i] + RATE_Q_W'(rrem[i] >= RATE_N_W'(RATE_DEN));
      rate_o_r[i] <= rs[i];
    end
    tn_r     <= tn;
    tq0_r    <= tprod[TEMP_K +: TEMP_Q_W];
    tq_r     <= tq0_r + TEMP_Q_W'(trem >= TEMP_N_W'(TEMP_DEN));
    temp_o_r <= ts[TEMP_W-1:0];
    roll_r   <= ay_r[ACC_W-1] ? -$signed(rollmag) : $signed(rollmag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NLANE; i++) begin
        bias_r[i] <= '0;
      end
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
      pos_r  <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (isc_reg_t'(cfg_index))
          REG_BIAS_X: bias_r[0] <= cfg_wdata;
          REG_BIAS_Y: bias_r[1] <= cfg_wdata;
          REG_BIAS_Z: bias_r[2] <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.win_upd) begin
        if (prime_r) begin
          for (int i = 0; i < WIN_LEN; i++) begin
            win_r[i] <= roll_r;
          end
          sum_r  <= SUM_W'(roll_r) * SUM_W'(WIN_LEN);
          pos_r  <= '0;
          fill_r <= CNT_W'(WIN_LEN);
        end else begin
          win_r[pos_r] <= roll_r;
          sum_r        <= sum_r - SUM_W'(win_r[pos_r]) + SUM_W'(roll_r);
          pos_r        <= (pos_r == POS_W'(WIN_LEN - 1)) ? '0 : pos_r + 1'b1;
          if (fill_r != CNT_W'(WIN_LEN)) begin
            fill_r <= fill_r + 1'b1;
          end
        end
      end
    end
  end

  isc_div u_div (
    .clk      (clk),
    .load     (cmd.div_load),
    .step     (cmd.div_step),
    .dividend (dvd),
    .divisor  (fill_r),
    .neg      (sum_r[SUM_W-1]),
    .quot     (mean)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      oax_r   <= ax_r;
      oay_r   <= ay_r;
      oaz_r   <= az_r;
      for (int i = 0; i < NLANE; i++) begin
        orate_r[i] <= rate_o_r[i];
      end
      otemp_r <= temp_o_r;
      oroll_r <= roll_r;
      omean_r <= mean;
    end
  end

  assign out_accel_x   = oax_r;
  assign out_accel_y   = oay_r;
  assign out_accel_z   = oaz_r;
  assign out_rate_x    = orate_r[0];
  assign out_rate_y    = orate_r[1];
  assign out_rate_z    = orate_r[2];
  assign out_temp_c    = otemp_r;
  assign out_roll      = oroll_r;
  assign out_roll_mean = omean_r;

endmodule

FILE: hw/rtl/imu_sample_conditioner.sv
// An accepted sample runs through CALC1, CALC2, CALC3, DIV and FIN to out_valid;
// FIN waits while a stalled result holds the result register. No sample is taken till idle.
// Three arithmetic stages plus the mean divider, resolving seven quotient bits a cycle.
// A prime sample returns to idle after the window update and gives no result.
// The result register holds a finished result while the next sample is taken in.
// Reset (synchronous, rst_n low) clears the sequencer, out_valid, biases and the window.
module imu_sample_conditioner (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [isc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [isc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [isc_pkg::ACC_W-1:0]      in_accel_x,
  input  logic signed [isc_pkg::ACC_W-1:0]      in_accel_y,
  input  logic signed [isc_pkg::ACC_W-1:0]      in_accel_z,
  input  logic signed [isc_pkg::RATE_IN_W-1:0]  in_rate_x,
  input  logic signed [isc_pkg::RATE_IN_W-1:0]  in_rate_y,
  input  logic signed [isc_pkg::RATE_IN_W-1:0]  in_rate_z,
  input  logic signed [isc_pkg::TEMP_IN_W-1:0]  in_raw_temp,
  input  logic                                  in_prime,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [isc_pkg::ACC_W-1:0]      out_accel_x,
  output logic signed [isc_pkg::ACC_W-1:0]      out_accel_y,
  output logic signed [isc_pkg::ACC_W-1:0]      out_accel_z,
  output logic signed [isc_pkg::RATE_OUT_W-1:0] out_rate_x,
  output logic signed [isc_pkg::RATE_OUT_W-1:0] out_rate_y,
  output logic signed [isc_pkg::RATE_OUT_W-1:0] out_rate_z,
  output logic signed [isc_pkg::TEMP_W-1:0]     out_temp_c,
  output logic signed [isc_pkg::ROLL_W-1:0]     out_roll,
  output logic signed [isc_pkg::ROLL_W-1:0]     out_roll_mean
);
  import isc_pkg::*;

  isc_cmd_t cmd;
  isc_sts_t sts;

  assign cfg_ready = 1'b1;

  isc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  isc_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_accel_x    (in_accel_x),
    .in_accel_y    (in_accel_y),
    .in_accel_z    (in_accel_z),
    .in_rate_x     (in_rate_x),
    .in_rate_y     (in_rate_y),
    .in_rate_z     (in_rate_z),
    .in_raw_temp   (in_raw_temp),
    .in_prime      (in_prime),
    .cmd           (cmd),
    .sts           (sts),
    .out_accel_x   (out_accel_x),
    .out_accel_y   (out_accel_y),
    .out_accel_z   (out_accel_z),
    .out_rate_x    (out_rate_x),
    .out_rate_y    (out_rate_y),
    .out_rate_z    (out_rate_z),
    .out_temp_c    (out_temp_c),
    .out_roll      (out_roll),
    .out_roll_mean (out_roll_mean)
  );

endmodule

FILE: hw/rtl/isc_checker.sv
module isc_sva_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  in_prime,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [isc_pkg::ROLL_W-1:0]     out_roll,
  input logic signed [isc_pkg::ROLL_W-1:0]     out_roll_mean
);
  import isc_pkg::*;

  logic in_acc;

  assign in_acc = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_roll) && $stable(out_roll_mean))
    else $error("stalled result transaction changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input transaction accepted while busy");

  a_prime_returns: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_prime |-> ##3 !in_stall)
    else $error("prime transaction did not return to idle");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear the handshake state");

endmodule

bind imu_sample_conditioner isc_sva_checker u_isc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_prime      (in_prime),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_roll      (out_roll),
  .out_roll_mean (out_roll_mean)
);

FILE: tb/isc_checker.sv
module isc_checker
  import isc_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic signed [ACC_W-1:0]      in_accel_x,
  input  logic signed [ACC_W-1:0]      in_accel_y,
  input  logic signed [ACC_W-1:0]      in_accel_z,
  input  logic signed [RATE_IN_W-1:0]  in_rate_x,
  input  logic signed [RATE_IN_W-1:0]  in_rate_y,
  input  logic signed [RATE_IN_W-1:0]  in_rate_z,
  input  logic signed [TEMP_IN_W-1:0]  in_raw_temp,
  input  logic                         in_prime,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [ACC_W-1:0]      out_accel_x,
  input  logic signed [ACC_W-1:0]      out_accel_y,
  input  logic signed [ACC_W-1:0]      out_accel_z,
  input  logic signed [RATE_OUT_W-1:0] out_rate_x,
  input  logic signed [RATE_OUT_W-1:0] out_rate_y,
  input  logic signed [RATE_OUT_W-1:0] out_rate_z,
  input  logic signed [TEMP_W-1:0]     out_temp_c,
  input  logic signed [ROLL_W-1:0]     out_roll,
  input  logic signed [ROLL_W-1:0]     out_roll_mean,
  output int                           mismatches,
  output int                           outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [ACC_W-1:0]      accel_x;
    logic signed [ACC_W-1:0]      accel_y;
    logic signed [ACC_W-1:0]      accel_z;
    logic signed [RATE_OUT_W-1:0] rate_x;
    logic signed [RATE_OUT_W-1:0] rate_y;
    logic signed [RATE_OUT_W-1:0] rate_z;
    logic signed [TEMP_W-1:0]     temp_c;
    logic signed [ROLL_W-1:0]     roll;
    logic signed [ROLL_W-1:0]     roll_mean;
  } reading_t;

  reading_t readings_q[$];

  longint bias_x;
  longint bias_y;
  longint bias_z;
  longint roll_win [WIN_LEN];
  int     win_pos;
  int     win_fill;
  longint win_sum;

  function automatic longint round_div(input longint num, input longint den);
    if (num >= 0) begin
      return (num + den / 2) / den;
    end
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint scale_rate(input longint raw, input longint bias);
    return round_div(raw * RATE_NUM, RATE_DEN) - bias;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic condition_sample();
    longint   roll;
    reading_t r;
    roll = round_div(longint'(in_accel_y) * ROLL_NUM, longint'(1) << ROLL_SH);
    if (in_prime) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        roll_win[i] = roll;
      end
      win_sum  = roll * WIN_LEN;
      win_pos  = 0;
      win_fill = WIN_LEN;
    end else begin
      win_sum           = win_sum - roll_win[win_pos] + roll;
      roll_win[win_pos] = roll;
      win_pos           = (win_pos + 1 >= WIN_LEN) ? 0 : win_pos + 1;
      if (win_fill < WIN_LEN) begin
        win_fill++;
      end
      r.accel_x   = in_accel_x;
      r.accel_y   = in_accel_y;
      r.accel_z   = in_accel_z;
      r.rate_x    = scale_rate(in_rate_x, bias_x);
      r.rate_y    = scale_rate(in_rate_y, bias_y);
      r.rate_z    = scale_rate(in_rate_z, bias_z);
      r.temp_c    = round_div(longint'(in_raw_temp) * TEMP_NUM, TEMP_DEN) + TEMP_OFS;
      r.roll      = roll;
      r.roll_mean = round_div(win_sum, win_fill);
      readings_q.push_back(r);
    end
  endtask

  task automatic compare_result();
    reading_t r;
    if (readings_q.size() == 0) begin
      report("result transaction with nothing expected");
    end else begin
      r = readings_q.pop_front();
      check_field("out_accel_x", out_accel_x, r.accel_x);
      check_field("out_accel_y", out_accel_y, r.accel_y);
      check_field("out_accel_z", out_accel_z, r.accel_z);
      check_field("out_rate_x", out_rate_x, r.rate_x);
      check_field("out_rate_y", out_rate_y, r.rate_y);
      check_field("out_rate_z", out_rate_z, r.rate_z);
      check_field("out_temp_c", out_temp_c, r.temp_c);
      check_field("out_roll", out_roll, r.roll);
      check_field("out_roll_mean", out_roll_mean, r.roll_mean);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      bias_x = 0;
      bias_y = 0;
      bias_z = 0;
      for (int i = 0; i < WIN_LEN; i++) begin
        roll_win[i] = 0;
      end
      win_pos  = 0;
      win_fill = 0;
      win_sum  = 0;
      readings_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        compare_result();
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BIAS_X: bias_x = longint'($signed(cfg_wdata));
          REG_BIAS_Y: bias_y = longint'($signed(cfg_wdata));
          REG_BIAS_Z: bias_z = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        condition_sample();
      end
    end
    outstanding <= readings_q.size();
  end

endmodule

FILE: tb/imu_sample_conditioner_test.sv
module imu_sample_conditioner_test
  import isc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int PHASE_ITEMS = 185;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [ACC_W-1:0]      in_accel_x = '0;
  logic signed [ACC_W-1:0]      in_accel_y = '0;
  logic signed [ACC_W-1:0]      in_accel_z = '0;
  logic signed [RATE_IN_W-1:0]  in_rate_x = '0;
  logic signed [RATE_IN_W-1:0]  in_rate_y = '0;
  logic signed [RATE_IN_W-1:0]  in_rate_z = '0;
  logic signed [TEMP_IN_W-1:0]  in_raw_temp = '0;
  logic                         in_prime = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [ACC_W-1:0]      out_accel_x;
  logic signed [ACC_W-1:0]      out_accel_y;
  logic signed [ACC_W-1:0]      out_accel_z;
  logic signed [RATE_OUT_W-1:0] out_rate_x;
  logic signed [RATE_OUT_W-1:0] out_rate_y;
  logic signed [RATE_OUT_W-1:0] out_rate_z;
  logic signed [TEMP_W-1:0]     out_temp_c;
  logic signed [ROLL_W-1:0]     out_roll;
  logic signed [ROLL_W-1:0]     out_roll_mean;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  imu_sample_conditioner u_top (.*);

  isc_checker u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= !steady && rst_n && ($urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send(input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
                      input logic [15:0] gx, input logic [15:0] gy, input logic [15:0] gz,
                      input logic [15:0] tr, input logic p);
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_accel_x  <= ax;
    in_accel_y  <= ay;
    in_accel_z  <= az;
    in_rate_x   <= gx;
    in_rate_y   <= gy;
    in_rate_z   <= gz;
    in_raw_temp <= tr;
    in_prime    <= p;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [15:0] ay;
    logic [15:0] gx;
    if ($urandom_range(0, 99) < 20) begin
      ay = 16'($urandom_range(0, 80)) - 16'd40;
    end else begin
      ay = 16'($urandom);
    end
    if ($urandom_range(0, 99) < 15) begin
      gx = 16'($urandom_range(0, 200)) - 16'd100;
    end else begin
      gx = 16'($urandom);
    end
    send(16'($urandom), ay, 16'($urandom), gx, 16'($urandom), 16'($urandom),
         16'($urandom), $urandom_range(0, 99) < 5);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_biases(input logic [15:0] bx, input logic [15:0] by,
                            input logic [15:0] bz);
    drain();
    write_reg(REG_BIAS_X, bx);
    write_reg(REG_BIAS_Y, by);
    write_reg(REG_SPARE, 16'($urandom));
    write_reg(REG_BIAS_Z, bz);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_bias();
    return 16'($urandom_range(0, 64000)) - 16'd32000;
  endfunction

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_biases(-32000, 32000, 1);
    send(0, 0, 0, 0, 0, 0, 0, 0);
    send(32767, 32767, 32767, 32767, 32767, 32767, 32767, 0);
    send(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0);
    send(1, 8, -1, 1, -1, 41, 1, 0);
    send(-1, -8, 1, -41, 20, -20, -1, 0);
    send(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 0);
    send(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 0);
    send(-32768, 32767, 32767, -32768, 32767, -32768, 32767, 1);
    send(0, -32768, 0, 0, 0, 0, 0, 0);
    send(0, 1, 0, 0, 0, 0, 0, 0);
    send(32767, -32768, -32768, 32767, -32768, 32767, -32768, 1);
    send(0, 0, 0, 0, 0, 0, 0, 1);
    send(0, 100, 0, 0, 0, 0, 0, 0);
    send(0, -100, 0, 0, 0, 0, 0, 0);
    send(0, 7, 0, 0, 0, 0, 0, 0);
    send(0, -7, 0, 0, 0, 0, 0, 0);
    send(0, 3000, 0, 0, 0, 0, 0, 0);
    send(0, -3000, 0, 0, 0, 0, 0, 0);
    send(0, 8, 0, 0, 0, 0, 0, 1);
    send(0, -24, 0, 0, 0, 0, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_biases(32000, -32000, 32000);
        1: set_biases(-32000, -32000, -32000);
        3: set_biases(0, 0, 0);
        default: set_biases(rand_bias(), rand_bias(), rand_bias());
      endcase
      steady = (ph == 2);
      repeat (PHASE_ITEMS) send_random();
    end
    steady = 1'b0;

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
